### rtl/assert_macros.svh
// Assertion macros of the checker file of the waveform sample generator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PWSG_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define PWSG_ASSERT(lbl, prop, msg) \
	`PWSG_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### rtl/pwsg_pkg.sv
// Shared types, codes and constants of the periodic waveform sample generator.
// No dependencies; imported by every module of the block.
package pwsg_pkg;

	localparam int unsigned MAX_POINTS = 256;

	// pipeline layout
	localparam int unsigned PIPE_DEPTH = 16;
	localparam int unsigned DIV_STAGES = 8;
	localparam int unsigned SINE_LAST  = 15;

	// trapezoid breakpoints
	localparam int unsigned RAMP_UP_END     = 25;
	localparam int unsigned RAMP_DOWN_START = 40;
	localparam int unsigned RAMP_DOWN_END   = 55;

	// reciprocals for the constant divisions of the trapezoid
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RAMP_DOWN_LEN = RAMP_DOWN_END - RAMP_DOWN_START;
	localparam logic [20:0] RECIP_UP   = 21'((64'd1 << RECIP_SHIFT) / RAMP_UP_END);
	localparam logic [20:0] RECIP_DOWN = 21'((64'd1 << RECIP_SHIFT) / RAMP_DOWN_LEN);

	// odd Taylor coefficients of sin(pi/2*x), Q30
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	typedef enum logic [2:0] {
		WAVE_SINE = 3'd0,
		WAVE_RECT = 3'd1,
		WAVE_TRAP = 3'd2,
		WAVE_OFF  = 3'd3
	} wave_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_BAD_TYPE = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_WAVE_TYPE  = 2'd0,
		REG_AMPLITUDE  = 2'd1,
		REG_OFFSET     = 2'd2,
		REG_PERIOD_LEN = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HOLD,
		SEG_FALL,
		SEG_ZERO
	} trap_seg_t;

	typedef struct packed {
		logic [2:0]  wave_type;
		logic [11:0] amplitude;
		logic [11:0] offset;
		logic [12:0] period_len;
	} cfg_t;

endpackage

### rtl/pwsg_ctrl.sv
// Valid bits and advance chain of the sample pipeline.
// Depends on pwsg_pkg.
module pwsg_ctrl
	import pwsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  out_stall,
	output logic [PIPE_DEPTH:1]   adv,
	output logic                  out_valid
);

	logic [PIPE_DEPTH:1] vld_q;

	// a stage moves on when it is empty or the stage after it moves
	assign adv[PIPE_DEPTH] = ~vld_q[PIPE_DEPTH] | ~out_stall;

	genvar k;
	generate
		for (k = 1; k < PIPE_DEPTH; k++) begin : g_adv
			assign adv[k] = ~vld_q[k] | adv[k+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int j = 2; j <= PIPE_DEPTH; j++) begin
				if (adv[j]) begin
					vld_q[j] <= vld_q[j-1];
				end
			end
		end
	end

	assign out_valid = vld_q[PIPE_DEPTH];

endmodule

### rtl/pwsg_div.sv
// Pipelined restoring divider: phase = (index * 65536) / period_len, two bits a stage.
// Depends on pwsg_pkg.
module pwsg_div
	import pwsg_pkg::*;
(
	input  logic                clk,
	input  logic [PIPE_DEPTH:1] adv,
	input  logic [12:0]         period_len,
	input  logic [11:0]         sample_index,
	output logic [15:0]         phase_s8
);

	logic [12:0] rem_s [1:DIV_STAGES];
	logic [15:0] quo_s [1:DIV_STAGES];

	function automatic logic [13:0] div_step(input logic [12:0] rem, input logic [12:0] len);
		logic [13:0] t;
		t = {rem, 1'b0};
		if (t >= {1'b0, len}) begin
			t = t - {1'b0, len};
			div_step = {1'b1, t[12:0]};
		end else begin
			div_step = {1'b0, t[12:0]};
		end
	endfunction

	genvar k;
	generate
		for (k = 1; k <= DIV_STAGES; k++) begin : g_stage
			logic [12:0] rem_in;
			logic [15:0] quo_in;
			logic [13:0] step_a;
			logic [13:0] step_b;

			if (k == 1) begin : g_first
				assign rem_in = {1'b0, sample_index};
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign quo_in = quo_s[k-1];
			end

			assign step_a = div_step(rem_in, period_len);
			assign step_b = div_step(step_a[12:0], period_len);

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k] <= step_b[12:0];
					quo_s[k] <= {quo_in[13:0], step_a[13], step_b[13]};
				end
			end
		end
	endgenerate

	assign phase_s8 = quo_s[DIV_STAGES];

endmodule

### rtl/pwsg_sine.sv
// Quarter-wave fold, Horner sine polynomial and amplitude scaling, stages 9 to 15.
// Depends on pwsg_pkg.
module pwsg_sine
	import pwsg_pkg::*;
(
	input  logic                clk,
	input  logic [PIPE_DEPTH:1] adv,
	input  logic [11:0]         amplitude,
	input  logic [15:0]         phase_s8,
	output logic [27:0]         mag_s15,
	output logic                neg_s15
);

	logic [14:0] r_s9, r_s10, r_s11, r_s12, r_s13;
	logic [30:0] x2_s9, x2_s10, x2_s11, x2_s12;
	logic        neg_s9, neg_s10, neg_s11, neg_s12, neg_s13, neg_s14;
	logic [61:0] prod_s10, prod_s11, prod_s12, prod_s13, prod_s14;

	logic [14:0] r_fold;
	logic [28:0] r_sq;
	logic [31:0] t7, t5, t3, t1;
	logic [32:0] s_round;
	logic [18:0] s_q16;
	logic [16:0] s_cap;

	// fold into the first quadrant; mirror the odd quadrants
	assign r_fold = phase_s8[14] ? (15'd16384 - {1'b0, phase_s8[13:0]}) : {1'b0, phase_s8[13:0]};
	assign r_sq   = 29'(r_fold * r_fold);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			r_s9   <= r_fold;
			x2_s9  <= {r_sq, 2'b00};
			neg_s9 <= phase_s8[15];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			r_s10    <= r_s9;
			x2_s10   <= x2_s9;
			neg_s10  <= neg_s9;
			prod_s10 <= x2_s9 * SIN_C9;
		end
	end

	assign t7 = {1'b0, SIN_C7} - prod_s10[61:30];

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			r_s11    <= r_s10;
			x2_s11   <= x2_s10;
			neg_s11  <= neg_s10;
			prod_s11 <= x2_s10 * t7[30:0];
		end
	end

	assign t5 = {1'b0, SIN_C5} - prod_s11[61:30];

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			r_s12    <= r_s11;
			x2_s12   <= x2_s11;
			neg_s12  <= neg_s11;
			prod_s12 <= x2_s11 * t5[30:0];
		end
	end

	assign t3 = {1'b0, SIN_C3} - prod_s12[61:30];

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			r_s13    <= r_s12;
			neg_s13  <= neg_s12;
			prod_s13 <= x2_s12 * t3[30:0];
		end
	end

	assign t1 = {1'b0, SIN_C1} - prod_s13[61:30];

	always_ff @(posedge clk) begin
		if (adv[14]) begin
			neg_s14  <= neg_s13;
			prod_s14 <= {r_s13, 16'd0} * t1[30:0];
		end
	end

	// round Q30 to Q16 and cap at one
	assign s_round = {1'b0, prod_s14[61:30]} + 33'd8192;
	assign s_q16   = s_round[32:14];
	assign s_cap   = (s_q16 > 19'd65536) ? 17'd65536 : s_q16[16:0];

	always_ff @(posedge clk) begin
		if (adv[SINE_LAST]) begin
			neg_s15 <= neg_s14;
			mag_s15 <= amplitude[11:1] * s_cap;
		end
	end

endmodule

### rtl/pwsg_shape.sv
// Status decode, rectangle and trapezoid samples, carried down to stage 15.
// Depends on pwsg_pkg.
module pwsg_shape
	import pwsg_pkg::*;
(
	input  logic                clk,
	input  logic [PIPE_DEPTH:1] adv,
	input  cfg_t                cfg,
	input  logic [11:0]         sample_index,
	output logic [12:0]         alt_s15,
	output status_t             status_s15
);

	status_t     st_in;
	trap_seg_t   seg_in;
	logic [5:0]  k_in;
	logic [12:0] rect_in;

	status_t     status_s1, status_s2;
	trap_seg_t   seg_s1, seg_s2;
	logic [16:0] n_s1, n_s2;
	logic [12:0] rect_s1, rect_s2;
	logic [11:0] qe_s2;

	logic [37:0] qe_prod;
	logic [4:0]  div_d;
	logic [17:0] rem_t;
	logic [11:0] q_fix;
	logic [11:0] trap_y;
	logic [12:0] alt_in;

	logic [12:0] alt_s  [3:SINE_LAST];
	status_t     stat_s [3:SINE_LAST];

	always_comb begin
		if (cfg.period_len == 13'd0 || cfg.period_len > 13'(MAX_POINTS)) begin
			st_in = ST_BAD_LEN;
		end else if (cfg.wave_type > WAVE_OFF) begin
			st_in = ST_BAD_TYPE;
		end else if (cfg.wave_type == WAVE_TRAP && cfg.period_len < 13'(MAX_POINTS)) begin
			st_in = ST_BAD_LEN;
		end else if ({1'b0, sample_index} >= cfg.period_len) begin
			st_in = ST_RANGE;
		end else begin
			st_in = ST_OK;
		end
	end

	always_comb begin
		if (sample_index <= 12'(RAMP_UP_END)) begin
			seg_in = SEG_RISE;
			k_in   = sample_index[5:0];
		end else if (sample_index < 12'(RAMP_DOWN_START)) begin
			seg_in = SEG_HOLD;
			k_in   = '0;
		end else if (sample_index < 12'(RAMP_DOWN_END)) begin
			seg_in = SEG_FALL;
			k_in   = 6'(12'(RAMP_DOWN_END) - sample_index);
		end else begin
			seg_in = SEG_ZERO;
			k_in   = '0;
		end
	end

	assign rect_in = (sample_index >= cfg.period_len[12:1]) ?
		({1'b0, cfg.amplitude} + {1'b0, cfg.offset}) : {1'b0, cfg.offset};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			status_s1 <= st_in;
			seg_s1    <= seg_in;
			n_s1      <= 17'(cfg.amplitude * k_in);
			rect_s1   <= rect_in;
		end
	end

	// estimate the quotient by reciprocal; it is exact or one short
	assign qe_prod = n_s1 * ((seg_s1 == SEG_RISE) ? RECIP_UP : RECIP_DOWN);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			status_s2 <= status_s1;
			seg_s2    <= seg_s1;
			n_s2      <= n_s1;
			rect_s2   <= rect_s1;
			qe_s2     <= qe_prod[RECIP_SHIFT+11:RECIP_SHIFT];
		end
	end

	assign div_d = (seg_s2 == SEG_RISE) ? 5'(RAMP_UP_END) : 5'(RAMP_DOWN_LEN);
	assign rem_t = {1'b0, n_s2} - 18'(qe_s2 * div_d);
	assign q_fix = (rem_t >= {13'd0, div_d}) ? (qe_s2 + 12'd1) : qe_s2;

	always_comb begin
		case (seg_s2)
			SEG_RISE: trap_y = q_fix;
			SEG_HOLD: trap_y = cfg.amplitude;
			SEG_FALL: trap_y = q_fix;
			SEG_ZERO: trap_y = '0;
			default:  trap_y = '0;
		endcase
	end

	always_comb begin
		case (cfg.wave_type)
			WAVE_RECT: alt_in = rect_s2;
			WAVE_TRAP: alt_in = {1'b0, trap_y} + {1'b0, cfg.offset};
			default:   alt_in = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			alt_s[3]  <= alt_in;
			stat_s[3] <= status_s2;
		end
	end

	genvar k;
	generate
		for (k = 4; k <= SINE_LAST; k++) begin : g_delay
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					alt_s[k]  <= alt_s[k-1];
					stat_s[k] <= stat_s[k-1];
				end
			end
		end
	endgenerate

	assign alt_s15    = alt_s[SINE_LAST];
	assign status_s15 = stat_s[SINE_LAST];

endmodule

### rtl/periodic_waveform_sample_gen_top.sv
// Top level of the periodic waveform sample generator: config registers, final stage.
// Depends on pwsg_pkg, pwsg_ctrl, pwsg_div, pwsg_sine and pwsg_shape.
//
// Usage:
//   Input channel: sample_index with in_valid / in_stall. A transaction
//   is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: sample_value and status with out_valid / out_stall.
//   Configuration: wr_en writes wr_data into the register picked by wr_index
//   (wave type, amplitude, offset, period length). Write only while the block
//   is idle: no transaction in flight.
//   Throughput: one transaction per cycle unless every stage is full and the
//   output is stalled; the 16 stages are the 8-stage phase divider (two
//   quotient bits a stage), a fold-and-square stage, five chained polynomial
//   multiplies, the amplitude scaling and the output register.
//   Stall: a stage moves when it is empty or the one after it moves, so
//   bubbles close up and input keeps flowing while a result waits. in_stall
//   rises only when every stage is full and the output is stalled.
//   Reset: clears all valid bits and loads wave type off, amplitude 0,
//   offset 0, period length 256.
module periodic_waveform_sample_gen_top
	import pwsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] sample_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] sample_value,
	output logic [1:0]  status,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data
);

	logic [2:0]  wave_type_q;
	logic [11:0] amplitude_q;
	logic [11:0] offset_q;
	logic [12:0] period_len_q;
	cfg_t        cfg;

	logic [PIPE_DEPTH:1] adv;
	logic [15:0]         phase_s8;
	logic [27:0]         mag_s15;
	logic                neg_s15;
	logic [12:0]         alt_s15;
	status_t             status_s15;

	logic [12:0] base_hi;
	logic [29:0] base_ext;
	logic [29:0] sine_sum;
	logic [12:0] val_next;

	logic [12:0] sample_value_s16;
	status_t     status_s16;

	// configuration registers; index decodes straight to a field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q  <= WAVE_OFF;
			amplitude_q  <= '0;
			offset_q     <= '0;
			period_len_q <= 13'd256;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_WAVE_TYPE:  wave_type_q  <= wr_data[2:0];
				REG_AMPLITUDE:  amplitude_q  <= wr_data[11:0];
				REG_OFFSET:     offset_q     <= wr_data[11:0];
				REG_PERIOD_LEN: period_len_q <= wr_data;
				default:        ;
			endcase
		end
	end

	assign cfg = '{wave_type: wave_type_q, amplitude: amplitude_q,
		offset: offset_q, period_len: period_len_q};

	// valid bits and the advance chain
	pwsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid)
	);

	assign in_stall = ~adv[1];

	// stages 1-8: sine phase
	pwsg_div u_div (
		.clk          (clk),
		.adv          (adv),
		.period_len   (period_len_q),
		.sample_index (sample_index),
		.phase_s8     (phase_s8)
	);

	// stages 9-15: sine magnitude scaled by half the amplitude
	pwsg_sine u_sine (
		.clk       (clk),
		.adv       (adv),
		.amplitude (amplitude_q),
		.phase_s8  (phase_s8),
		.mag_s15   (mag_s15),
		.neg_s15   (neg_s15)
	);

	// stages 1-15: status, rectangle and trapezoid
	pwsg_shape u_shape (
		.clk          (clk),
		.adv          (adv),
		.cfg          (cfg),
		.sample_index (sample_index),
		.alt_s15      (alt_s15),
		.status_s15   (status_s15)
	);

	// centre level (h + offset) in Q16, then add or drop the magnitude
	assign base_hi  = {2'b00, amplitude_q[11:1]} + {1'b0, offset_q};
	assign base_ext = {1'b0, base_hi, 16'd0};
	assign sine_sum = neg_s15 ? (base_ext - {2'b00, mag_s15}) : (base_ext + {2'b00, mag_s15});

	always_comb begin
		if (status_s15 != ST_OK) begin
			val_next = '0;
		end else if (wave_type_q == WAVE_SINE) begin
			val_next = sine_sum[28:16];
		end else begin
			val_next = alt_s15;
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk) begin
		if (adv[PIPE_DEPTH]) begin
			sample_value_s16 <= val_next;
			status_s16       <= status_s15;
		end
	end

	assign sample_value = sample_value_s16;
	assign status       = status_s16;

endmodule

### rtl/pwsg_chk.sv
// Port-level checker of the waveform sample generator, bound to the top level.
// Depends on pwsg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwsg_chk
	import pwsg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [11:0] sample_index,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] sample_value,
	input logic [1:0]  status,
	input logic        wr_en,
	input logic [1:0]  wr_index,
	input logic [12:0] wr_data
);

	// a stalled result stays put
	`PWSG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(sample_value) && $stable(status), "stalled result changed")

	// input back-pressure only when the last stage is full and blocked
	`PWSG_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with room in pipeline")

	// any error code forces a zero sample
	`PWSG_ASSERT(a_err_zero, out_valid && status != ST_OK |-> sample_value == 13'd0, "nonzero sample with error status")

	// no valid waveform exceeds the top code
	`PWSG_ASSERT(a_max_code, out_valid |-> sample_value <= 13'd8190, "sample above top code")

endmodule

bind periodic_waveform_sample_gen_top pwsg_chk u_pwsg_chk (.*);

### tb/testbench.sv
// Self-checking testbench of periodic_waveform_sample_gen_top: sine, rectangle, trapezoid and off
// samples are predicted in a scoreboard class and checked as results come out.
// Depends on pwsg_pkg and the block's RTL.
module testbench;
	import pwsg_pkg::*;

	// Predicts one DAC code per accepted sample index and checks results in order.
	class sample_ledger;
		typedef struct packed {
			logic [12:0] value;
			status_t     status;
		} sample_t;

		cfg_t    regs;
		sample_t pending_samples[$];
		int      errors;

		function new();
			regs.wave_type  = WAVE_OFF;
			regs.amplitude  = '0;
			regs.offset     = '0;
			regs.period_len = 13'(MAX_POINTS);
			errors          = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [12:0] data);
			case (idx)
				REG_WAVE_TYPE:  regs.wave_type  = data[2:0];
				REG_AMPLITUDE:  regs.amplitude  = data[11:0];
				REG_OFFSET:     regs.offset     = data[11:0];
				REG_PERIOD_LEN: regs.period_len = data;
				default: ;
			endcase
		endfunction

		// sin(pi/2 * r/16384) in Q16 via the Q30 Horner polynomial
		function logic [63:0] quarter_wave(logic [63:0] r);
			logic [63:0] x, x2, t, s;
			x  = r << 16;
			x2 = (x * x) >> 30;
			t  = 64'(SIN_C9);
			t  = 64'(SIN_C7) - ((x2 * t) >> 30);
			t  = 64'(SIN_C5) - ((x2 * t) >> 30);
			t  = 64'(SIN_C3) - ((x2 * t) >> 30);
			t  = 64'(SIN_C1) - ((x2 * t) >> 30);
			s  = (x * t) >> 30;
			s  = (s + 64'd8192) >> 14;
			if (s > 64'd65536)
				s = 64'd65536;
			return s;
		endfunction

		function logic [63:0] sine_code(logic [63:0] i, logic [63:0] a, logic [63:0] o,
				logic [63:0] len);
			logic [63:0] h, p, q, r, mag, base;
			h = a >> 1;
			p = ((i << 16) / len) & 64'hFFFF;
			q = p >> 14;
			r = p & 64'h3FFF;
			if (q[0])
				r = 64'd16384 - r;
			mag  = h * quarter_wave(r);
			base = (h + o) << 16;
			if (q >= 64'd2)
				return (base - mag) >> 16;
			return (base + mag) >> 16;
		endfunction

		function sample_t predict_sample(logic [11:0] idx);
			sample_t     res;
			logic [63:0] a, o, len, i, y;
			res.value  = '0;
			res.status = ST_OK;
			a   = 64'(regs.amplitude);
			o   = 64'(regs.offset);
			len = 64'(regs.period_len);
			i   = 64'(idx);
			if (len == 0 || len > MAX_POINTS)
				res.status = ST_BAD_LEN;
			else if (regs.wave_type > WAVE_OFF)
				res.status = ST_BAD_TYPE;
			else if (regs.wave_type == WAVE_TRAP && len < MAX_POINTS)
				res.status = ST_BAD_LEN;
			else if (i >= len)
				res.status = ST_RANGE;
			else begin
				case (regs.wave_type)
					WAVE_SINE: res.value = 13'(sine_code(i, a, o, len));
					WAVE_RECT: res.value = 13'((i >= (len >> 1)) ? a + o : o);
					WAVE_TRAP: begin
						if (i <= RAMP_UP_END)
							y = (a * i) / RAMP_UP_END;
						else if (i < RAMP_DOWN_START)
							y = a;
						else if (i < RAMP_DOWN_END)
							y = (a * (RAMP_DOWN_END - i)) / (RAMP_DOWN_END - RAMP_DOWN_START);
						else
							y = 0;
						res.value = 13'(y + o);
					end
					default: res.value = '0;
				endcase
			end
			return res;
		endfunction

		function void note_index(logic [11:0] idx);
			pending_samples.push_back(predict_sample(idx));
		endfunction

		function int pending();
			return pending_samples.size();
		endfunction

		task report(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		task check_result(logic [12:0] value, logic [1:0] st);
			sample_t want;
			if (pending_samples.size() == 0) begin
				report($sformatf("result with nothing pending: value %0d status %0d",
					value, st));
				return;
			end
			want = pending_samples.pop_front();
			if (value !== want.value)
				report($sformatf("sample_value %0d, predicted %0d", value, want.value));
			if (st !== want.status)
				report($sformatf("status %0d, predicted %0d", st, want.status));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_stall;
	logic [11:0] sample_index;
	logic        out_valid;
	logic        out_stall;
	logic [12:0] sample_value;
	logic [1:0]  status;
	logic        wr_en;
	reg_idx_t    wr_index;
	logic [12:0] wr_data;

	sample_ledger ledger = new();

	// idling switches, changed per phase by the stimulus process
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	// ask the result sink for one long hold-off
	bit long_hold = 1'b0;

	periodic_waveform_sample_gen_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value),
		.status       (status),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one sample index after an optional gap; hold it until the transaction is taken.
	task automatic send_index(logic [11:0] idx);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_index <= idx;
		do @(posedge clk); while (in_stall);
		ledger.note_index(idx);
	endtask

	// Drop valid and wait until every predicted sample has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		ledger.set_reg(idx, data);
	endtask

	// Reprogram all four registers once the pipeline is empty; spare upper data bits
	// are filled at random, since the block keeps only the register width.
	task automatic program_regs(logic [2:0] wt, logic [11:0] amp, logic [11:0] off,
			logic [12:0] len);
		drain_results();
		write_reg(REG_WAVE_TYPE,  {10'($urandom_range(0, 1023)), wt});
		write_reg(REG_AMPLITUDE,  {1'($urandom_range(0, 1)), amp});
		write_reg(REG_OFFSET,     {1'($urandom_range(0, 1)), off});
		write_reg(REG_PERIOD_LEN, len);
		wr_en <= 1'b0;
	endtask

	function automatic logic [11:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return 12'd0;
			1:       return 12'hFFF;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// Mostly indices inside the period; the rest anywhere in the 12-bit range.
	function automatic logic [11:0] pick_index(logic [12:0] len);
		if (len != 0 && len <= MAX_POINTS && $urandom_range(0, 4) != 0)
			return 12'($urandom_range(0, int'(len) - 1));
		return 12'($urandom_range(0, 4095));
	endfunction

	// Result sink: draw a stall per transaction, or serve one long hold-off when asked,
	// so the pipeline fills up and pushes back on the input.
	initial begin : result_sink
		int wait_cycles;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold   = 1'b0;
				wait_cycles = 120;
			end else begin
				wait_cycles = rx_gaps ? $urandom_range(0, 16) : 0;
			end
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			ledger.check_result(sample_value, status);
		end
	end

	initial begin : stimulus
		int         sent;
		int         phase;
		int         count;
		logic [2:0]  wt;
		logic [12:0] len;
		in_valid     <= 1'b0;
		sample_index <= '0;
		wr_en        <= 1'b0;
		wr_index     <= REG_WAVE_TYPE;
		wr_data      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: off, length 256 - zero inside the period, range error beyond it.
		send_index(12'd0);
		send_index(12'hFFF);

		// Sine at full swing and full offset: peak, trough and both ends of the period.
		program_regs(WAVE_SINE, 12'hFFF, 12'hFFF, 13'(MAX_POINTS));
		send_index(12'd0);
		send_index(12'd64);
		send_index(12'd192);
		send_index(12'd255);
		// Single-sample period with zero swing.
		program_regs(WAVE_SINE, 12'd0, 12'd0, 13'd1);
		send_index(12'd0);

		// Rectangle either side of the half period, then a one-sample period.
		program_regs(WAVE_RECT, 12'hFFF, 12'd0, 13'(MAX_POINTS));
		send_index(12'd127);
		send_index(12'd128);
		program_regs(WAVE_RECT, 12'hFFF, 12'hFFF, 13'd1);
		send_index(12'd0);

		// Trapezoid at every breakpoint.
		program_regs(WAVE_TRAP, 12'hFFF, 12'hFFF, 13'(MAX_POINTS));
		send_index(12'd0);
		send_index(12'd25);
		send_index(12'd26);
		send_index(12'd39);
		send_index(12'd40);
		send_index(12'd54);
		send_index(12'd55);
		send_index(12'd255);
		// Trapezoid with a short period is a length error.
		program_regs(WAVE_TRAP, 12'hFFF, 12'd0, 13'd255);
		send_index(12'd0);

		// Invalid type, then zero, just-too-long and maximum lengths.
		program_regs(3'd7, 12'hFFF, 12'hFFF, 13'(MAX_POINTS));
		send_index(12'd0);
		program_regs(WAVE_SINE, 12'd100, 12'd5, 13'd0);
		send_index(12'd0);
		program_regs(3'd5, 12'd100, 12'd5, 13'd257);
		send_index(12'd0);
		program_regs(WAVE_RECT, 12'd100, 12'd5, 13'h1FFF);
		send_index(12'd0);

		// Random phases: fresh settings each time, idling switched per phase.
		sent  = 0;
		phase = 0;
		while (sent < 1600) begin
			wt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
				: 3'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0:       len = 13'd0;
				1:       len = 13'($urandom_range(MAX_POINTS + 1, 8191));
				2:       len = 13'd1;
				3, 4:    len = 13'(MAX_POINTS);
				default: len = 13'($urandom_range(1, MAX_POINTS));
			endcase
			if (wt == WAVE_TRAP && $urandom_range(0, 3) != 0)
				len = 13'(MAX_POINTS);
			program_regs(wt, pick_level(), pick_level(), len);
			tx_gaps = ($urandom_range(0, 2) != 0);
			rx_gaps = ($urandom_range(0, 2) != 0);
			count   = $urandom_range(20, 80);
			// one phase with back-to-back input against a long output hold-off
			if (phase == 2) begin
				tx_gaps   = 1'b0;
				long_hold = 1'b1;
				count     = 80;
			end
			repeat (count) send_index(pick_index(len));
			sent += count;
			phase++;
		end

		drain_results();
		// leave room for any stray result past the pipeline depth
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (ledger.errors == 0)
			$display("periodic_waveform_sample_gen_top regression: pass");
		else
			$display("periodic_waveform_sample_gen_top regression: fail");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("periodic_waveform_sample_gen_top regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/pwsg_pkg.sv
rtl/pwsg_ctrl.sv
rtl/pwsg_div.sv
rtl/pwsg_sine.sv
rtl/pwsg_shape.sv
rtl/periodic_waveform_sample_gen_top.sv
rtl/pwsg_chk.sv
tb/testbench.sv
